// ----- rtl/core/rcc_pkg.sv -----
// Shared types and constants for the reference-counted render cache.
// Depends on nothing; used by the entry memory and the top level.
package rcc_pkg;

	localparam int MAX_RESULTS = 16;
	localparam logic [15:0] REFS_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		OP_LOOKUP  = 2'd0,
		OP_INSERT  = 2'd1,
		OP_RELEASE = 2'd2,
		OP_PURGE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_READ,
		ST_CHECK,
		ST_END,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		REG_CACHE_LIMIT   = 2'd0,
		REG_TIMER_PRESENT = 2'd1,
		REG_GRADIENT_MASK = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] size;
		logic [31:0] texture;
		logic [31:0] pixel_a;
		logic [31:0] pixel_b;
		logic [31:0] handle;
		logic [15:0] refs;
	} entry_t;

	typedef struct packed {
		logic        table_full;
		logic        freed;
		logic        hit;
		logic [31:0] handle;
	} result_t;

endpackage

// ----- rtl/core/rcc_entry_mem.sv -----
// Entry table storage: one write port, one registered read port.
// Depends on rcc_pkg for the entry layout.
module rcc_entry_mem #(
	parameter int DEPTH = 16,
	parameter int AW = 4
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  rcc_pkg::entry_t wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output rcc_pkg::entry_t rdata
);
	import rcc_pkg::*;

	entry_t mem_q [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read data holds while no read is issued, so a stalled check keeps its entry.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/refcounted_render_cache.sv -----
// Reference-counted render cache: an ordered table of cached images with counts,
// searched, updated and compacted by a sequencer over one entry memory.
// Depends on rcc_pkg and rcc_entry_mem.
//
// One request is taken at a time. A lookup or release walks the valid entries
// in order (memory read, then compare and write back); a lookup stops at its
// first hit. An insert writes one entry and, when the count then passes
// cache_limit, runs a purge; a release runs one after its walk when timer_present
// is clear. A purge walks all valid entries the same way, moving the kept ones
// down in place; each freed handle is one output word, the last marked by tlast.
// A stalled output side holds a purge walk. Configure only while idle.
module refcounted_render_cache #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	// tdata: img_width, img_height, texture_flags, first_pixel, second_pixel,
	// image_handle (lowest bits first)
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [159:0]  s_tdata,
	input  logic [1:0]    s_tuser,   // kind
	// tdata: found_handle
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [31:0]   m_tdata,
	output logic [2:0]    m_tuser,   // hit, freed, table_full
	output logic          m_tlast,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	import rcc_pkg::*;

	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	// Configuration registers.
	logic [4:0]  cache_limit_q;
	logic        timer_present_q;
	logic [31:0] gradient_mask_q;
	logic        cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cache_limit_q   <= 5'd16;
			timer_present_q <= 1'b1;
			gradient_mask_q <= '0;
		end else if (cfg_we) begin
			unique case (paddr[3:2])
				REG_CACHE_LIMIT:   cache_limit_q   <= pwdata[4:0];
				REG_TIMER_PRESENT: timer_present_q <= pwdata[0];
				REG_GRADIENT_MASK: gradient_mask_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_CACHE_LIMIT:   prdata = {27'd0, cache_limit_q};
			REG_TIMER_PRESENT: prdata = {31'd0, timer_present_q};
			REG_GRADIENT_MASK: prdata = gradient_mask_q;
			default:           prdata = '0;
		endcase
	end

	// Request registers.
	op_t         op_q, op_d;
	logic [31:0] size_q, tex_q, pa_q, pb_q, handle_q;
	logic        grad_q;

	// Sequencer state.
	state_t          state_q, state_d;
	logic [AW-1:0]   idx_q, idx_d;
	logic [AW-1:0]   wr_q, wr_d;
	logic [CW-1:0]   used_q, used_d;
	logic [4:0]      cnt_q, cnt_d;
	logic            pend_valid_q, pend_valid_d;
	result_t         pend_q, pend_d;
	logic            pend_last;

	// Output register.
	logic    out_valid_q;
	result_t out_q;
	logic    out_last_q;
	logic    can_push, push;

	// Memory port.
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr;
	entry_t        mem_wdata, rd;

	rcc_entry_mem #(.DEPTH(TABLE_ENTRIES), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (idx_q),
		.rdata (rd)
	);

	logic          scan_done;
	logic          match;
	logic [CW-1:0] idx_ext;
	logic          start_purge;

	assign can_push  = !out_valid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign idx_ext   = CW'(idx_q);
	assign scan_done = (idx_ext + 1'b1) == used_q;
	assign match     = (rd.size == size_q) && (rd.texture == tex_q) &&
	                   (rd.pixel_a == pa_q) && (!grad_q || rd.pixel_b == pb_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		op_d         = op_q;
		idx_d        = idx_q;
		wr_d         = wr_q;
		used_d       = used_q;
		cnt_d        = cnt_q;
		pend_valid_d = pend_valid_q;
		pend_d       = pend_q;
		pend_last    = 1'b0;
		push         = 1'b0;
		mem_we       = 1'b0;
		mem_re       = 1'b0;
		mem_waddr    = idx_q;
		mem_wdata    = rd;
		start_purge  = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				pend_d       = '0;
				pend_valid_d = 1'b1;
				idx_d        = '0;
				unique case (op_q)
					OP_LOOKUP: begin
						state_d = (used_q == '0) ? ST_FINISH : ST_READ;
					end
					OP_INSERT: begin
						if (handle_q == '0) begin
							state_d = ST_FINISH;
						end else if (used_q >= CW'(TABLE_ENTRIES)) begin
							pend_d.table_full = 1'b1;
							state_d = ST_FINISH;
						end else begin
							mem_we    = 1'b1;
							mem_waddr = used_q[AW-1:0];
							mem_wdata = '{size: size_q, texture: tex_q, pixel_a: pa_q,
								pixel_b: (grad_q ? pb_q : 32'd0), handle: handle_q,
								refs: 16'd1};
							used_d = used_q + 1'b1;
							if ((8'(used_q) + 8'd1) > 8'(cache_limit_q)) begin
								start_purge = 1'b1;
							end else begin
								state_d = ST_FINISH;
							end
						end
					end
					OP_RELEASE: begin
						if (handle_q == '0) begin
							state_d = ST_FINISH;
						end else begin
							state_d = (used_q == '0) ? ST_END : ST_READ;
						end
					end
					OP_PURGE: begin
						start_purge = 1'b1;
					end
					default: ;
				endcase
			end
			ST_READ: begin
				mem_re  = 1'b1;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				unique case (op_q)
					OP_LOOKUP: begin
						if (match) begin
							mem_we = 1'b1;
							if (rd.refs != REFS_MAX) begin
								mem_wdata.refs = rd.refs + 16'd1;
							end
							pend_d.hit    = 1'b1;
							pend_d.handle = rd.handle;
							state_d = ST_FINISH;
						end else begin
							idx_d   = idx_q + 1'b1;
							state_d = scan_done ? ST_END : ST_READ;
						end
					end
					OP_RELEASE: begin
						if (rd.handle == handle_q && rd.refs != '0) begin
							mem_we = 1'b1;
							mem_wdata.refs = rd.refs - 16'd1;
						end
						idx_d   = idx_q + 1'b1;
						state_d = scan_done ? ST_END : ST_READ;
					end
					default: begin
						// Purge: report a zero-count entry or move a kept one down.
						if (rd.refs == '0 && cnt_q < 5'(MAX_RESULTS)) begin
							if (!pend_valid_q || can_push) begin
								push          = pend_valid_q;
								pend_valid_d  = 1'b1;
								pend_d        = '0;
								pend_d.freed  = 1'b1;
								pend_d.handle = rd.handle;
								cnt_d   = cnt_q + 5'd1;
								idx_d   = idx_q + 1'b1;
								state_d = scan_done ? ST_END : ST_READ;
							end
						end else begin
							mem_we    = (wr_q != idx_q);
							mem_waddr = wr_q;
							wr_d      = wr_q + 1'b1;
							idx_d     = idx_q + 1'b1;
							state_d   = scan_done ? ST_END : ST_READ;
						end
					end
				endcase
			end
			ST_END: begin
				unique case (op_q)
					OP_RELEASE: begin
						if (timer_present_q) begin
							state_d = ST_FINISH;
						end else begin
							start_purge = 1'b1;
						end
					end
					OP_PURGE: begin
						// Kept entries: the count before the walk less the freed ones.
						used_d = used_q - CW'(cnt_q);
						if (!pend_valid_q) begin
							pend_valid_d = 1'b1;
							pend_d       = '0;
						end
						state_d = ST_FINISH;
					end
					default: begin
						state_d = ST_FINISH;
					end
				endcase
			end
			ST_FINISH: begin
				if (can_push) begin
					push      = 1'b1;
					pend_last = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (start_purge) begin
			op_d         = OP_PURGE;
			idx_d        = '0;
			wr_d         = '0;
			cnt_d        = '0;
			pend_valid_d = 1'b0;
			state_d      = (used_d == '0) ? ST_END : ST_READ;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q         <= OP_LOOKUP;
			idx_q        <= '0;
			wr_q         <= '0;
			used_q       <= '0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			op_q         <= (state_q == ST_IDLE && s_tvalid) ? op_t'(s_tuser) : op_d;
			idx_q        <= idx_d;
			wr_q         <= wr_d;
			used_q       <= used_d;
			cnt_q        <= cnt_d;
			pend_valid_q <= (state_q == ST_FINISH && can_push) ? 1'b0 : pend_valid_d;
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pend_q <= pend_d;
		if (push) begin
			out_q      <= pend_q;
			out_last_q <= pend_last;
		end
		if (state_q == ST_IDLE && s_tvalid) begin
			size_q   <= {s_tdata[15:0], s_tdata[31:16]};
			tex_q    <= s_tdata[63:32];
			pa_q     <= s_tdata[95:64];
			pb_q     <= s_tdata[127:96];
			handle_q <= s_tdata[159:128];
			grad_q   <= (s_tdata[63:32] & gradient_mask_q) != '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q.handle;
	assign m_tuser  = {out_q.table_full, out_q.freed, out_q.hit};
	assign m_tlast  = out_last_q;

endmodule
